// File: design/indexed_array_insert_store_top_macros.svh
// Assertion macros for the indexed array insert store.
`ifndef INDEXED_ARRAY_INSERT_STORE_TOP_MACROS_SVH
`define INDEXED_ARRAY_INSERT_STORE_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define IAS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define IAS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IAS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define IAS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: design/ias_pkg.sv
// Shared types and constants for the indexed array insert store.
`default_nettype none
package ias_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int MODE_W    = 3;
  localparam int POS_W     = 8;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int FILL_W    = 6;

  // Command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_POP    = 3'd2,
    MODE_GET    = 3'd3,
    MODE_CLEAR  = 3'd4,
    MODE_SIZE   = 3'd5,
    MODE_PRINT  = 3'd6
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

endpackage
`default_nettype wire

// File: design/ias_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module ias_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: design/indexed_array_insert_store_top.sv
// Push, pop, clear and size run in the exec state and load their result from the response state;
// a get or print in range reads memory in exec and loads words from the read-out state. Insert in
// the middle moves each word up with a read state and a write state, then writes the new word.
// Print gives one word per cycle while out is not stalled. One command at a time: the next is
// taken once the last result sits in the output register.
// Reset clears the word count and control state; the word memory is not cleared.
`default_nettype none
`include "indexed_array_insert_store_top_macros.svh"
module indexed_array_insert_store_top #(
  parameter int DEPTH = ias_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // command channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ias_pkg::MODE_W-1:0]          in_mode,
  input  wire logic [ias_pkg::POS_W-1:0]           in_position,
  input  wire logic signed [ias_pkg::WORD_W-1:0]   in_word_in,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [ias_pkg::WORD_W-1:0]        out_word_out,
  output logic [ias_pkg::STATUS_W-1:0]             out_status,
  output logic [ias_pkg::FILL_W-1:0]               out_fill_count,
  output logic                                     out_last
);
  import ias_pkg::*;

  localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EXEC   = 7'b0000010,
    ST_RESP   = 7'b0000100,
    ST_RD_OUT = 7'b0001000,
    ST_SH_RD  = 7'b0010000,
    ST_SH_WR  = 7'b0100000,
    ST_INS_WR = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic [IDXW-1:0]      idx_r, idx_nxt;

  // latched command
  mode_t                cmd_mode_r;
  logic [POS_W-1:0]     cmd_pos_r;
  logic [WORD_W-1:0]    cmd_word_r;

  // pending status result
  status_t              res_status_r, res_status_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]    out_word_r;
  status_t              out_status_r;
  logic [FILL_W-1:0]    out_fill_r;
  logic                 out_last_r;

  // output load request
  logic                 ld_out;
  logic [WORD_W-1:0]    ld_word;
  status_t              ld_status;
  logic                 ld_last;

  // memory port
  logic                 ram_we;
  logic [IDXW-1:0]      ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [IDXW-1:0]      ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  logic                 in_acc;
  logic                 slot_free;
  logic                 full;
  logic [POS_W-1:0]     cnt_ext;
  logic [IDXW-1:0]      pos_idx;
  logic [IDXW-1:0]      idx_dec;
  logic                 print_last;

  ias_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_word_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign slot_free  = !out_valid_r || !out_stall;
  assign full       = (cnt_r == CNTW'(DEPTH));
  assign cnt_ext    = POS_W'(cnt_r);
  // position is only used as an index once it is known to be below the depth
  assign pos_idx    = cmd_pos_r[IDXW-1:0];
  assign idx_dec    = idx_r - IDXW'(1);
  assign print_last = ((CNTW'(idx_r) + CNTW'(1)) == cnt_r);

  // Command sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[IDXW-1:0];
    ram_wdata      = cmd_word_r;
    ram_re         = 1'b0;
    ram_raddr      = pos_idx;
    ld_out         = 1'b0;
    ld_word        = '0;
    ld_status      = STAT_OK;
    ld_last        = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_status_nxt = STAT_OK;
        state_nxt      = ST_RESP;
        case (cmd_mode_r)
          MODE_PUSH: begin
            if (full) begin
              res_status_nxt = STAT_FULL;
            end else begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + CNTW'(1);
            end
          end
          MODE_INSERT: begin
            // range check comes before the full check
            if (cmd_pos_r > cnt_ext) begin
              res_status_nxt = STAT_RANGE;
            end else if (full) begin
              res_status_nxt = STAT_FULL;
            end else if (cmd_pos_r == cnt_ext) begin
              ram_we    = 1'b1;
              ram_waddr = pos_idx;
              cnt_nxt   = cnt_r + CNTW'(1);
            end else begin
              idx_nxt   = cnt_r[IDXW-1:0];
              state_nxt = ST_SH_RD;
            end
          end
          MODE_POP: begin
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - CNTW'(1);
            end
          end
          MODE_GET: begin
            if (cmd_pos_r >= cnt_ext) begin
              res_status_nxt = STAT_RANGE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = pos_idx;
              state_nxt = ST_RD_OUT;
            end
          end
          MODE_CLEAR: begin
            cnt_nxt = '0;
          end
          MODE_PRINT: begin
            if (cnt_r == '0) begin
              res_status_nxt = STAT_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              idx_nxt   = '0;
              state_nxt = ST_RD_OUT;
            end
          end
          default: begin
            // size and unused codes only report the count
          end
        endcase
      end

      ST_RESP: begin
        if (slot_free) begin
          ld_out    = 1'b1;
          ld_status = res_status_r;
          state_nxt = ST_IDLE;
        end
      end

      // Word from memory to output; print streams the next read behind it
      ST_RD_OUT: begin
        if (slot_free) begin
          ld_out  = 1'b1;
          ld_word = ram_rdata;
          ld_last = (cmd_mode_r != MODE_PRINT) || print_last;
          if (ld_last) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + IDXW'(1);
            idx_nxt   = idx_r + IDXW'(1);
          end
        end
      end

      // Shift one word up: read below, then write at the current index
      ST_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_dec;
        state_nxt = ST_SH_WR;
      end

      ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_dec;
        state_nxt = (idx_dec == pos_idx) ? ST_INS_WR : ST_SH_RD;
      end

      ST_INS_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = pos_idx;
        cnt_nxt        = cnt_r + CNTW'(1);
        res_status_nxt = STAT_OK;
        state_nxt      = ST_RESP;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    if (in_acc) begin
      cmd_mode_r <= mode_t'(in_mode);
      cmd_pos_r  <= in_position;
      cmd_word_r <= in_word_in;
    end
    if (ld_out) begin
      out_word_r   <= ld_word;
      out_status_r <= ld_status;
      out_fill_r   <= FILL_W'(cnt_r);
      out_last_r   <= ld_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word_out   = out_word_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;
  assign out_last       = out_last_r;

  // Checks
  `IAS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNTW'(DEPTH), "count above depth")
  `IAS_ASSERT_NXT(a_acc_exec, clk, rst_n, in_acc, state_r == ST_EXEC, "accept not followed by exec")
  `IAS_ASSERT_IMP(a_wr_addr, clk, rst_n, ram_we, CNTW'(ram_waddr) <= cnt_r, "write past count")
  `IAS_ASSERT_IMP(a_ld_free, clk, rst_n, ld_out, slot_free, "output overwritten while stalled")

endmodule
`default_nettype wire

// File: tb/ias_result_checker.sv
// Result checker for the indexed array insert store: predicts each result and compares it.
`timescale 1ns / 1ps
module ias_result_checker #(
  parameter int DEPTH = ias_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [ias_pkg::MODE_W-1:0]          in_mode,
  input  wire logic [ias_pkg::POS_W-1:0]           in_position,
  input  wire logic signed [ias_pkg::WORD_W-1:0]   in_word_in,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic signed [ias_pkg::WORD_W-1:0]   out_word_out,
  input  wire logic [ias_pkg::STATUS_W-1:0]        out_status,
  input  wire logic [ias_pkg::FILL_W-1:0]          out_fill_count,
  input  wire logic                                out_last,
  output int                                       fail_count,
  output int                                       pending_count
);
  import ias_pkg::*;

  // Cap on printed mismatch lines; counting goes on past it
  localparam int PRINT_CAP = 100;

  typedef struct {
    logic signed [WORD_W-1:0] data;
    status_t                  code;
    logic [FILL_W-1:0]        fill;
    logic                     is_last;
  } array_result_t;

  // Shadow copy of the array
  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  int unsigned              shadow_count;
  array_result_t            expected_words [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    shadow_count  = 0;
  end

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("checker: %s at %0t ns: got %0h, expected %0h", what, $time, got, want);
  endtask

  // Queue one expected word; fill reflects the count after the command
  task automatic queue_result(input logic signed [WORD_W-1:0] data, input status_t code,
                              input logic is_last);
    array_result_t r;
    r.data    = data;
    r.code    = code;
    r.fill    = FILL_W'(shadow_count);
    r.is_last = is_last;
    expected_words.insert(expected_words.size(), r);
  endtask

  // Apply one command to the shadow array and queue what it returns
  task automatic predict_command(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                                 input logic signed [WORD_W-1:0] data);
    int unsigned idx;
    case (mode)
      MODE_PUSH: begin
        if (shadow_count >= DEPTH) begin
          queue_result('0, STAT_FULL, 1'b1);
        end else begin
          shadow_words[shadow_count] = data;
          shadow_count++;
          queue_result('0, STAT_OK, 1'b1);
        end
      end
      MODE_INSERT: begin
        // range check comes before the full check
        if (pos > shadow_count) begin
          queue_result('0, STAT_RANGE, 1'b1);
        end else if (shadow_count >= DEPTH) begin
          queue_result('0, STAT_FULL, 1'b1);
        end else begin
          for (idx = shadow_count; idx > pos; idx--)
            shadow_words[idx] = shadow_words[idx-1];
          shadow_words[pos] = data;
          shadow_count++;
          queue_result('0, STAT_OK, 1'b1);
        end
      end
      MODE_POP: begin
        if (shadow_count > 0)
          shadow_count--;
        queue_result('0, STAT_OK, 1'b1);
      end
      MODE_GET: begin
        if (pos >= shadow_count)
          queue_result('0, STAT_RANGE, 1'b1);
        else
          queue_result(shadow_words[pos], STAT_OK, 1'b1);
      end
      MODE_CLEAR: begin
        shadow_count = 0;
        queue_result('0, STAT_OK, 1'b1);
      end
      MODE_PRINT: begin
        if (shadow_count == 0) begin
          queue_result('0, STAT_EMPTY, 1'b1);
        end else begin
          for (idx = 0; idx < shadow_count; idx++)
            queue_result(shadow_words[idx], STAT_OK, idx + 1 == shadow_count);
        end
      end
      // size and the unused code just report
      default: queue_result('0, STAT_OK, 1'b1);
    endcase
  endtask

  // Results first, then the command taken on the same edge
  always @(posedge clk) begin
    array_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word", out_word_out, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_word_out !== want.data)
            report_mismatch("word_out", out_word_out, want.data);
          if (out_status !== want.code)
            report_mismatch("status", WORD_W'(out_status), WORD_W'(want.code));
          if (out_fill_count !== want.fill)
            report_mismatch("fill_count", WORD_W'(out_fill_count), WORD_W'(want.fill));
          if (out_last !== want.is_last)
            report_mismatch("last", WORD_W'(out_last), WORD_W'(want.is_last));
        end
      end
      if (in_valid && !in_stall)
        predict_command(in_mode, in_position, in_word_in);
    end
    pending_count = expected_words.size();
  end

endmodule

// File: tb/tb_indexed_array_insert_store_top.sv
// Testbench top for the indexed array insert store: clock, reset, command stimulus, verdict.
`timescale 1ns / 1ps
module tb_indexed_array_insert_store_top;
  import ias_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int RANDOM_CMDS    = 390;
  localparam int WATCHDOG_LIMIT = 1500;
  localparam int TAIL_CYCLES    = 80;
  localparam int LONG_HOLD      = 250;
  // Code outside the command set
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  // Random block profiles
  localparam int PROFILE_GROW  = 0;
  localparam int PROFILE_MIXED = 1;
  localparam int PROFILE_DRAIN = 2;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [MODE_W-1:0]        in_mode;
  logic [POS_W-1:0]         in_position;
  logic signed [WORD_W-1:0] in_word_in;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [WORD_W-1:0] out_word_out;
  logic [STATUS_W-1:0]      out_status;
  logic [FILL_W-1:0]        out_fill_count;
  logic                     out_last;
  int                       fail_count;
  int                       pending_count;

  // Idling controls for sender and receiver, and the watchdog's idle count
  bit tx_calm;
  bit rx_calm;
  int rx_wait;
  int long_hold;
  int idle_cycles;

  indexed_array_insert_store_top #(.DEPTH(DEPTH)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_position    (in_position),
    .in_word_in     (in_word_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_out   (out_word_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count),
    .out_last       (out_last)
  );

  ias_result_checker #(.DEPTH(DEPTH)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_position    (in_position),
    .in_word_in     (in_word_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_out   (out_word_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall after each taken result (none when calm), plus one long hold on request
  initial begin
    out_stall = 1'b0;
    rx_wait   = 0;
    long_hold = 0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall)
      rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one command after a random gap and hold it until taken
  task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                          input logic signed [WORD_W-1:0] data);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_position <= pos;
    in_word_in  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random command shaped by the block profile
  task automatic send_random_cmd(input int profile);
    int                roll;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    roll = $urandom_range(0, 99);
    mode = MODE_W'($urandom_range(0, 7));
    case (profile)
      PROFILE_GROW: begin
        if (roll < 55)      mode = MODE_PUSH;
        else if (roll < 85) mode = MODE_INSERT;
        else if (roll < 90) mode = MODE_GET;
        else if (roll < 95) mode = MODE_PRINT;
      end
      PROFILE_DRAIN: begin
        if (roll < 50)      mode = MODE_POP;
        else if (roll < 65) mode = MODE_GET;
        else if (roll < 75) mode = MODE_PRINT;
        else if (roll < 80) mode = MODE_CLEAR;
        else if (roll < 85) mode = MODE_SIZE;
      end
      default: begin
        // keep clears rare so the array holds words
        if (mode == MODE_CLEAR && $urandom_range(0, 3) != 0)
          mode = MODE_GET;
      end
    endcase
    // mostly within 0 to DEPTH + 2, sometimes anywhere in the field
    if ($urandom_range(0, 99) < 80)
      pos = POS_W'($urandom_range(0, DEPTH + 2));
    else
      pos = POS_W'($urandom_range(0, 255));
    send_cmd(mode, pos, $urandom);
  endtask

  // Stimulus and verdict
  initial begin
    int sent;
    int blk;
    int blk_len;
    int profile;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_mode     = MODE_PUSH;
    in_position = '0;
    in_word_in  = '0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty cases, extremes, middle insert, range errors, unused code
    send_cmd(MODE_POP,    8'd0,   32'sd0);
    send_cmd(MODE_PRINT,  8'd0,   32'sd0);
    send_cmd(MODE_GET,    8'd0,   32'sd0);
    send_cmd(MODE_INSERT, 8'd1,   32'sd5);
    send_cmd(MODE_INSERT, 8'd0,   32'sh8000_0000);
    send_cmd(MODE_PUSH,   8'd0,   32'sh7fff_ffff);
    send_cmd(MODE_PUSH,   8'd255, -32'sd1);
    send_cmd(MODE_INSERT, 8'd1,   32'sd0);
    send_cmd(MODE_INSERT, 8'd4,   32'sh1234_5678);
    send_cmd(MODE_INSERT, 8'd6,   32'sd9);
    send_cmd(MODE_GET,    8'd0,   32'sd0);
    send_cmd(MODE_GET,    8'd4,   32'sd0);
    send_cmd(MODE_GET,    8'd5,   32'sd0);
    send_cmd(MODE_GET,    8'd255, 32'sd0);
    send_cmd(MODE_SIZE,   8'd0,   32'sd0);
    send_cmd(MODE_PRINT,  8'd0,   32'sd0);
    send_cmd(MODE_UNUSED, 8'd255, -32'sd1);
    send_cmd(MODE_POP,    8'd0,   32'sd0);
    send_cmd(MODE_SIZE,   8'd0,   32'sd0);
    send_cmd(MODE_CLEAR,  8'd0,   32'sd0);
    send_cmd(MODE_SIZE,   8'd0,   32'sd0);
    send_cmd(MODE_PRINT,  8'd0,   32'sd0);
    send_cmd(MODE_PUSH,   8'd0,   32'sh5555_5555);
    send_cmd(MODE_PUSH,   8'd0,   32'shaaaa_aaaa);
    send_cmd(MODE_GET,    8'd1,   32'sd0);

    // Random blocks; every third one grows the array toward full
    sent = 0;
    blk  = 0;
    while (sent < RANDOM_CMDS) begin
      profile = (blk % 3 == 0) ? PROFILE_GROW : $urandom_range(PROFILE_GROW, PROFILE_DRAIN);
      blk_len = $urandom_range(20, 45);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      // one long receiver hold while commands keep coming
      if (blk == 1) begin
        tx_calm   = 1'b1;
        long_hold = LONG_HOLD;
      end
      for (int k = 0; k < blk_len && sent < RANDOM_CMDS; k++) begin
        send_random_cmd(profile);
        sent++;
      end
      blk++;
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/ias_pkg.sv
design/ias_ram.sv
design/indexed_array_insert_store_top.sv
tb/ias_result_checker.sv
tb/tb_indexed_array_insert_store_top.sv
